// File: src/gec_pkg.sv
// Package for the greedy element coloring block.
// Holds store sizes, field widths, item kind codes and config register indices; depends on nothing.
package gec_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_CORNERS  = 8;
  localparam int MAX_NODES    = 4096;
  localparam int DOF_SPAN     = 4096;

  localparam int ELEM_W  = 10;
  localparam int CORN_W  = 3;
  localparam int NODE_W  = 12;
  localparam int DOF_W   = 12;
  localparam int VAL_W   = 11;
  localparam int NUSE_W  = 4;
  localparam int COLOR_W = VAL_W + 1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_MAP    = 2'd0;
  localparam kind_t KIND_CORNER = 2'd1;
  localparam kind_t KIND_RUN    = 2'd2;
  localparam kind_t KIND_READ   = 2'd3;

  localparam logic CFG_NODES = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

endpackage

// File: src/gec_ram.sv
// Single-port synchronous RAM with a registered read, one access per cycle.
// Stands alone; instantiated for every store of the coloring block.
module gec_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/greedy_element_coloring_top.sv
// Top level of the greedy element coloring block: sequencer and its four stores.
// Depends on gec_pkg and gec_ram.
//
// One item is taken at a time. A run first marks its ne elements uncolored,
// then per round clears the DOF mask over (dof_high - dof_low + 1) entries and
// visits each element, plus, per element still uncolored, checks its nn corners
// (the check stops at the first marked DOF) and, if none is marked, marks them,
// where ne and nn are the clamped element and corner counts. After reset the
// block clears every entry of the color store before it takes items.
module greedy_element_coloring_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gec_pkg::kind_t        in_kind,
  input  logic [9:0]            in_element,
  input  logic [2:0]            in_corner,
  input  logic [11:0]           in_node,
  input  logic [11:0]           in_dof,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [10:0]           out_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [10:0]           cfg_data
);
  import gec_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INV   = 4'd2;
  localparam logic [3:0] S_MCLR  = 4'd3;
  localparam logic [3:0] S_EREAD = 4'd4;
  localparam logic [3:0] S_ECHK  = 4'd5;
  localparam logic [3:0] S_C1    = 4'd6;
  localparam logic [3:0] S_C2    = 4'd7;
  localparam logic [3:0] S_C3    = 4'd8;
  localparam logic [3:0] S_MARK  = 4'd9;
  localparam logic [3:0] S_NEXT  = 4'd10;
  localparam logic [3:0] S_RDC   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  localparam int CADDR_W = ELEM_W + CORN_W;

  logic [3:0]         state_r, state_nxt;
  logic [ELEM_W-1:0]  e_r, e_nxt;
  logic [CORN_W-1:0]  c_r, c_nxt;
  logic [DOF_W-1:0]   m_r, m_nxt;
  logic [VAL_W-1:0]   round_r, round_nxt;
  logic               unc_r, unc_nxt;
  logic [VAL_W-1:0]   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;
  logic [NUSE_W-1:0]  nodes_r, nodes_nxt;
  logic [VAL_W-1:0]   count_r, count_nxt;
  logic [DOF_W-1:0]   low_r, low_nxt;
  logic [DOF_W-1:0]   high_r, high_nxt;
  logic [VAL_W-1:0]   ne_r, ne_nxt;
  logic [NUSE_W-1:0]  nn_r, nn_nxt;
  logic [DOF_W-1:0]   slot_r [MAX_CORNERS];
  logic [DOF_W-1:0]   slot_nxt;
  logic               slot_we;

  logic               col_we;
  logic [ELEM_W-1:0]  col_addr;
  logic [COLOR_W-1:0] col_wd, col_q;
  logic               cor_we;
  logic [CADDR_W-1:0] cor_addr;
  logic [NODE_W-1:0]  cor_wd, cor_q;
  logic               map_we;
  logic [NODE_W-1:0]  map_addr;
  logic [DOF_W-1:0]   map_wd, map_q;
  logic               msk_we;
  logic [DOF_W-1:0]   msk_addr;
  logic               msk_wd, msk_q;

  logic               last_e, last_c;
  logic [DOF_W-1:0]   span, offset;
  logic [VAL_W-1:0]   ne_clamp;
  logic [NUSE_W-1:0]  nn_clamp;

  gec_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(COLOR_W)) u_color (
    .clk(clk), .we(col_we), .addr(col_addr), .wdata(col_wd), .rdata(col_q));
  gec_ram #(.DEPTH(MAX_ELEMENTS * MAX_CORNERS), .WIDTH(NODE_W)) u_corner (
    .clk(clk), .we(cor_we), .addr(cor_addr), .wdata(cor_wd), .rdata(cor_q));
  gec_ram #(.DEPTH(MAX_NODES), .WIDTH(DOF_W)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wd), .rdata(map_q));
  gec_ram #(.DEPTH(DOF_SPAN), .WIDTH(1)) u_mask (
    .clk(clk), .we(msk_we), .addr(msk_addr), .wdata(msk_wd), .rdata(msk_q));

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign last_e   = ({1'b0, e_r} == ne_r - VAL_W'(1));
  assign last_c   = ({1'b0, c_r} == nn_r - NUSE_W'(1));
  assign span     = high_r - low_r;
  assign offset   = map_q - low_r;
  assign ne_clamp = (count_r > VAL_W'(MAX_ELEMENTS)) ? VAL_W'(MAX_ELEMENTS) : count_r;
  assign nn_clamp = (nodes_r > NUSE_W'(MAX_CORNERS)) ? NUSE_W'(MAX_CORNERS) : nodes_r;

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    c_nxt         = c_r;
    m_nxt         = m_r;
    round_nxt     = round_r;
    unc_nxt       = unc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    nodes_nxt     = nodes_r;
    count_nxt     = count_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    ne_nxt        = ne_r;
    nn_nxt        = nn_r;
    slot_we       = 1'b0;
    slot_nxt      = offset;
    col_we   = 1'b0;
    col_addr = e_r;
    col_wd   = '0;
    cor_we   = 1'b0;
    cor_addr = {e_r, c_r};
    cor_wd   = in_node;
    map_we   = 1'b0;
    map_addr = cor_q;
    map_wd   = in_dof;
    msk_we   = 1'b0;
    msk_addr = m_r;
    msk_wd   = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODES: nodes_nxt = cfg_data[NUSE_W-1:0];
        CFG_COUNT: count_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_INIT: begin
        col_we = 1'b1;
        if (e_r == ELEM_W'(MAX_ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          e_nxt = e_r + ELEM_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
          unique case (in_kind)
            KIND_MAP: begin
              map_we   = 1'b1;
              map_addr = in_node;
              if (in_dof < low_r) low_nxt = in_dof;
              if (in_dof > high_r) high_nxt = in_dof;
            end
            KIND_CORNER: begin
              cor_we   = 1'b1;
              cor_addr = {in_element, in_corner};
            end
            KIND_READ: begin
              col_addr  = in_element;
              state_nxt = S_RDC;
            end
            KIND_RUN: begin
              ne_nxt = ne_clamp;
              nn_nxt = nn_clamp;
              e_nxt  = '0;
              if (ne_clamp != '0) state_nxt = S_INV;
            end
            default: ;
          endcase
        end
      end
      S_INV: begin
        col_we = 1'b1;
        if (last_e) begin
          round_nxt = '0;
          m_nxt     = '0;
          state_nxt = S_MCLR;
        end else begin
          e_nxt = e_r + ELEM_W'(1);
        end
      end
      S_MCLR: begin
        msk_we = 1'b1;
        if (m_r == span) begin
          e_nxt     = '0;
          unc_nxt   = 1'b0;
          state_nxt = S_EREAD;
        end else begin
          m_nxt = m_r + DOF_W'(1);
        end
      end
      S_EREAD: begin
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        priority if (col_q[VAL_W]) begin
          state_nxt = S_NEXT;
        end else if (nn_r == '0) begin
          col_we    = 1'b1;
          col_wd    = {1'b1, round_r};
          state_nxt = S_NEXT;
        end else begin
          c_nxt     = '0;
          cor_addr  = {e_r, CORN_W'(0)};
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        state_nxt = S_C2;
      end
      S_C2: begin
        slot_we   = 1'b1;
        msk_addr  = offset;
        state_nxt = S_C3;
      end
      S_C3: begin
        priority if (msk_q) begin
          unc_nxt   = 1'b1;
          state_nxt = S_NEXT;
        end else if (last_c) begin
          c_nxt     = '0;
          state_nxt = S_MARK;
        end else begin
          c_nxt     = c_r + CORN_W'(1);
          cor_addr  = {e_r, c_r + CORN_W'(1)};
          state_nxt = S_C1;
        end
      end
      S_MARK: begin
        msk_we   = 1'b1;
        msk_addr = slot_r[c_r];
        msk_wd   = 1'b1;
        if (last_c) begin
          col_we    = 1'b1;
          col_wd    = {1'b1, round_r};
          state_nxt = S_NEXT;
        end else begin
          c_nxt = c_r + CORN_W'(1);
        end
      end
      S_NEXT: begin
        if (last_e) begin
          round_nxt = round_r + VAL_W'(1);
          if (unc_r) begin
            m_nxt     = '0;
            state_nxt = S_MCLR;
          end else begin
            res_nxt   = round_r + VAL_W'(1);
            state_nxt = S_FIN;
          end
        end else begin
          e_nxt     = e_r + ELEM_W'(1);
          state_nxt = S_EREAD;
        end
      end
      S_RDC: begin
        res_nxt   = col_q[VAL_W] ? col_q[VAL_W-1:0] : '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      e_r         <= '0;
      c_r         <= '0;
      m_r         <= '0;
      round_r     <= '0;
      unc_r       <= 1'b0;
      out_valid_r <= 1'b0;
      nodes_r     <= NUSE_W'(MAX_CORNERS);
      count_r     <= '0;
      low_r       <= '1;
      high_r      <= '0;
      ne_r        <= '0;
      nn_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      e_r         <= e_nxt;
      c_r         <= c_nxt;
      m_r         <= m_nxt;
      round_r     <= round_nxt;
      unc_r       <= unc_nxt;
      out_valid_r <= out_valid_nxt;
      nodes_r     <= nodes_nxt;
      count_r     <= count_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      ne_r        <= ne_nxt;
      nn_r        <= nn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    if (slot_we) begin
      slot_r[c_r] <= slot_nxt;
    end
  end

  a_corner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C1 || state_r == S_C2 || state_r == S_C3 || state_r == S_MARK)
      |-> ({1'b0, c_r} < nn_r))
    else $error("corner counter beyond corner count");

  a_write_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_MAP || in_kind == KIND_CORNER))
      |=> (state_r == S_FIN))
    else $error("write item did not go to result stage");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside result stage");

endmodule

// File: test/greedy_element_coloring_top_test.sv
// Self-checking testbench for greedy_element_coloring_top.
// Drives map, corner, run and read items against a built-in coloring predictor.
// Depends on gec_pkg and the block's RTL.
`timescale 1ns / 100ps

module greedy_element_coloring_top_test;
  import gec_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int ELEM_POOL = 32;

  typedef struct {
    logic is_cfg;
    kind_t kind;
    logic [9:0] element;
    logic [2:0] corner;
    logic [11:0] node;
    logic [11:0] dof;
    logic has_value;
    logic [10:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kind_t in_kind = KIND_MAP;
  logic [9:0] in_element = '0;
  logic [2:0] in_corner = '0;
  logic [11:0] in_node = '0;
  logic [11:0] in_dof = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [10:0] out_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_NODES;
  logic [10:0] cfg_data = '0;

  greedy_element_coloring_top dut (.*);

  // Predictor state.
  logic [11:0] node_dof [MAX_NODES];
  logic [11:0] corner_node [MAX_ELEMENTS][MAX_CORNERS];
  logic [10:0] elem_color [MAX_ELEMENTS];
  bit color_ok [MAX_ELEMENTS];
  bit node_mapped [MAX_NODES];
  bit corner_set [MAX_ELEMENTS][MAX_CORNERS];
  logic [11:0] dof_floor = 12'd4095;
  logic [3:0] corners_cfg = 4'd8;
  logic [10:0] count_cfg = '0;
  int mapped_nodes[$];

  logic [10:0] value_expect_q[$];
  int fails = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int corners_clamped();
    return (corners_cfg > MAX_CORNERS) ? MAX_CORNERS : corners_cfg;
  endfunction

  function automatic int elements_clamped();
    return (count_cfg > MAX_ELEMENTS) ? MAX_ELEMENTS : count_cfg;
  endfunction

  function automatic int dof_slot(int e, int c);
    logic [11:0] d;
    d = node_dof[corner_node[e][c]];
    return int'(12'(d - dof_floor));
  endfunction

  function automatic logic [10:0] color_mesh();
    bit used [DOF_SPAN];
    int ne, nn, left, rounds;
    bit clear;
    ne = elements_clamped();
    nn = corners_clamped();
    if (ne == 0) return '0;
    for (int e = 0; e < ne; e++) color_ok[e] = 1'b0;
    left = ne;
    rounds = 0;
    while (left > 0) begin
      foreach (used[i]) used[i] = 1'b0;
      left = 0;
      for (int e = 0; e < ne; e++) begin
        if (!color_ok[e]) begin
          clear = 1'b1;
          for (int c = 0; c < nn; c++)
            if (used[dof_slot(e, c)]) clear = 1'b0;
          if (clear) begin
            for (int c = 0; c < nn; c++) used[dof_slot(e, c)] = 1'b1;
            elem_color[e] = 11'(rounds);
            color_ok[e] = 1'b1;
          end else begin
            left++;
          end
        end
      end
      rounds++;
    end
    return 11'(rounds);
  endfunction

  function automatic logic [10:0] predict_item(kind_t k, logic [9:0] e, logic [2:0] c,
                                               logic [11:0] n, logic [11:0] d);
    case (k)
      KIND_MAP: begin
        node_dof[n] = d;
        if (!node_mapped[n]) mapped_nodes.push_back(n);
        node_mapped[n] = 1'b1;
        if (d < dof_floor) dof_floor = d;
        return '0;
      end
      KIND_CORNER: begin
        corner_node[e][c] = n;
        corner_set[e][c] = 1'b1;
        return '0;
      end
      KIND_RUN: return color_mesh();
      default: return color_ok[e] ? elem_color[e] : 11'd0;
    endcase
  endfunction

  // Largest element count whose used corners are all loaded.
  function automatic int loaded_prefix(int nn);
    for (int e = 0; e < MAX_ELEMENTS; e++)
      for (int c = 0; c < nn; c++)
        if (!corner_set[e][c]) return e;
    return MAX_ELEMENTS;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(kind_t k, logic [9:0] e, logic [2:0] c, logic [11:0] n,
                           logic [11:0] d, logic has_value = 1'b0,
                           logic [10:0] value = '0);
    int gap;
    logic [10:0] predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_element <= e;
    in_corner <= c;
    in_node <= n;
    in_dof <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_item(k, e, c, n, d);
    value_expect_q.push_back(has_value ? value : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (value_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NODES) corners_cfg = data[3:0];
    else count_cfg = data;
    @(posedge clk);
  endtask

  task automatic set_mesh(logic [3:0] nn, logic [10:0] ne);
    write_reg(CFG_NODES, {7'd0, nn});
    write_reg(CFG_COUNT, ne);
  endtask

  always @(posedge clk) begin
    logic [10:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (value_expect_q.size() == 0) begin
        $error("unexpected item: value got %0d", out_value);
        fails++;
      end else begin
        want = value_expect_q.pop_front();
        if (out_value !== want) begin
          $error("value mismatch: expected %0d, actual %0d", want, out_value);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r, len;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
        repeat (len - 1) @(posedge clk);
      end
    end
  end

  stim_row_t directed [] = '{
    '{0, KIND_READ,   10'd0,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{0, KIND_READ,   10'd1023, 3'd7, 12'd4095, 12'd4095, 1, 11'd0},
    '{0, KIND_RUN,    10'd0,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{0, KIND_MAP,    10'd0,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{0, KIND_MAP,    10'd1023, 3'd7, 12'd4095, 12'd4095, 1, 11'd0},
    '{0, KIND_MAP,    10'd0,    3'd0, 12'hAAA,  12'h555,  1, 11'd0},
    '{0, KIND_MAP,    10'd0,    3'd0, 12'h555,  12'hAAA,  1, 11'd0},
    '{0, KIND_CORNER, 10'd0,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{0, KIND_CORNER, 10'd0,    3'd1, 12'd4095, 12'd0,    1, 11'd0},
    '{0, KIND_CORNER, 10'd1,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{0, KIND_CORNER, 10'd1,    3'd1, 12'hAAA,  12'd0,    1, 11'd0},
    '{0, KIND_CORNER, 10'd2,    3'd0, 12'h555,  12'd0,    1, 11'd0},
    '{0, KIND_CORNER, 10'd2,    3'd1, 12'hAAA,  12'd0,    1, 11'd0},
    '{0, KIND_CORNER, 10'd1023, 3'd7, 12'd4095, 12'd4095, 1, 11'd0},
    '{0, KIND_CORNER, 10'd1023, 3'd0, 12'h555,  12'd0,    1, 11'd0},
    '{0, KIND_RUN,    10'd0,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{1, KIND_MAP,    10'd0,    3'd0, 12'd2,    12'd3,    0, 11'd0},
    '{0, KIND_RUN,    10'd0,    3'd0, 12'd0,    12'd0,    0, 11'd0},
    '{0, KIND_READ,   10'd0,    3'd0, 12'd0,    12'd0,    0, 11'd0},
    '{0, KIND_READ,   10'd1,    3'd0, 12'd0,    12'd0,    0, 11'd0},
    '{0, KIND_READ,   10'd2,    3'd0, 12'd0,    12'd0,    0, 11'd0},
    '{0, KIND_READ,   10'd3,    3'd0, 12'd0,    12'd0,    1, 11'd0},
    '{1, KIND_MAP,    10'd0,    3'd0, 12'd0,    12'd2047, 0, 11'd0},
    '{0, KIND_RUN,    10'd0,    3'd0, 12'd0,    12'd0,    1, 11'd1},
    '{0, KIND_READ,   10'd1023, 3'd0, 12'd0,    12'd0,    1, 11'd0}
  };

  initial begin
    int sent, r, nn, cap, e, n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      if (directed[i].is_cfg)
        set_mesh(directed[i].node[3:0], directed[i].dof[10:0]);
      else
        send_item(directed[i].kind, directed[i].element, directed[i].corner,
                  directed[i].node, directed[i].dof, directed[i].has_value,
                  directed[i].value);
    end
    sent = directed.size();

    while (mapped_nodes.size() < 48) begin
      n = $urandom_range(0, MAX_NODES - 1);
      if (!node_mapped[n]) begin
        send_item(KIND_MAP, 10'($urandom), 3'($urandom), 12'(n), 12'($urandom));
        sent++;
      end
    end
    for (int i = 0; i < ELEM_POOL; i++)
      for (int c = 0; c < MAX_CORNERS; c++) begin
        send_item(KIND_CORNER, 10'(i), 3'(c),
                  12'(mapped_nodes[$urandom_range(0, mapped_nodes.size() - 1)]),
                  12'($urandom));
        sent++;
      end
    set_mesh(4'd15, 11'd24);
    send_item(KIND_RUN, 10'($urandom), 3'($urandom), 12'($urandom), 12'($urandom));
    sent++;

    while (sent < 1400) begin
      if (sent == 800) hold_req = 1'b1;
      r = $urandom_range(0, 999);
      if (r < 10) begin
        nn = $urandom_range(0, 15);
        cap = loaded_prefix((nn > MAX_CORNERS) ? MAX_CORNERS : nn);
        if (cap > 24) cap = 24;
        set_mesh(4'(nn), 11'($urandom_range(0, cap)));
      end else if (r < 40) begin
        send_item(KIND_RUN, 10'($urandom), 3'($urandom), 12'($urandom), 12'($urandom));
        sent++;
      end else begin
        e = ($urandom_range(0, 9) < 7) ? $urandom_range(0, ELEM_POOL + 3)
                                       : $urandom_range(0, MAX_ELEMENTS - 1);
        if (r < 300) begin
          n = $urandom_range(0, MAX_NODES - 1);
          if (!node_mapped[n]) begin
            send_item(KIND_MAP, 10'(e), 3'($urandom), 12'(n), 12'($urandom));
            sent++;
          end
        end else if (r < 620) begin
          send_item(KIND_CORNER, 10'(e), 3'($urandom),
                    12'(mapped_nodes[$urandom_range(0, mapped_nodes.size() - 1)]),
                    12'($urandom));
          sent++;
        end else begin
          send_item(KIND_READ, 10'(e), 3'($urandom), 12'($urandom), 12'($urandom));
          sent++;
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
